[rtl/gnag_pkg.sv]
// Shared types and constants of the grid neighbour address generator.
// Used by gnag_ctrl, gnag_datapath and grid_neighbour_address_generator.
package gnag_pkg;

   // grid geometry and field widths
   localparam int GRID_SIDE  = 8;
   localparam int ADDR_W     = 8;
   localparam int CELL_W     = 6;
   localparam int RADIUS_W   = 3;
   localparam int RADIUS_MAX = 4;
   localparam int RADIUS_RST = 2;

   // counters for row distance and column distance (hold 0 .. RADIUS_MAX+1)
   localparam int CNT_W = $clog2(RADIUS_MAX + 2);
   // row/column positions incl. overshoot by up to RADIUS_MAX+1
   localparam int POS_W = $clog2(GRID_SIDE + RADIUS_MAX + 1);
   // width of the full row * side + column product before masking
   localparam int IDX_W = 2 * POS_W;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_RADIUS = 1'b0;

   // row selection codes
   localparam logic [1:0] ROW_OWN  = 2'd0;
   localparam logic [1:0] ROW_UP   = 2'd1;
   localparam logic [1:0] ROW_DOWN = 2'd2;

   // column selection codes
   localparam logic [1:0] COL_CENTRE = 2'd0;
   localparam logic [1:0] COL_LEFT   = 2'd1;
   localparam logic [1:0] COL_RIGHT  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic       flush;
      logic       d_next;
      logic       d_reset;
      logic       k_next;
      logic       k_reset;
      logic       full_reach;
      logic [1:0] row_sel;
      logic [1:0] col_sel;
   } cmd_type;

   typedef struct packed {
      logic adv;
      logic up_ok;
      logic dn_ok;
      logic left_ok;
      logic right_ok;
      logic d_at_r;
   } status_type;

endpackage

[rtl/grid_neighbour_address_generator.sv]
// Top level of the grid neighbour address generator: radius register and APB port.
// Depends on gnag_pkg, gnag_ctrl and gnag_datapath.
//
// Usage: the req channel carries one cell index (row * side + column) per transfer;
// the rsp channel returns the neighbouring cells within the radius, one per
// transfer, clipped at the grid edges, with rsp_is_last marking the final one.
// Order: rows above (nearest first), rows below, then the own row; a row above or
// below gives its center cell, then (but for the farthest) cells to the left and
// to the right, while the own row gives only cells to the left and to the right.
// An index outside the grid, or a radius of zero, gives no transfer at all.
// The radius register (byte address 0) is to be written over the csr APB port only
// while the block is idle, which the block itself does not enforce; values above
// four act as four. Reset sets it to two.
// Throughput: one item at a time; req_stall stays high from acceptance until the
// last cell has been handed to the output register.
// Lookahead: a cell moves to the output register at the next scan step that finds
// a cell or ends the scan, since one cell is held back to know whether it is the
// last. A stalled rsp holds its payload and freezes the scan; reset clears the
// controller, the pending cell and the output register.
module grid_neighbour_address_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gnag_pkg::ADDR_W-1:0]          req_cell_address,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gnag_pkg::CELL_W-1:0]          rsp_neighbour_cell,
   output logic                                 rsp_is_last,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gnag_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [gnag_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [gnag_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [gnag_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic                          csr_write;
   logic                          csr_hit;
   gnag_pkg::cmd_type             cmd;
   gnag_pkg::status_type          status;

   // register index is the word address; only the radius register exists
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[gnag_pkg::CSR_ADDR_W-1:2] == gnag_pkg::REG_RADIUS;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      radius_in = radius_ff;
      if (csr_write && csr_hit) begin
         radius_in = csr_pwdata[gnag_pkg::RADIUS_W-1:0];
      end
      // read back the register; addresses beyond it read as zero
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = gnag_pkg::CSR_DATA_W'(radius_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= gnag_pkg::RADIUS_W'(gnag_pkg::RADIUS_RST);
      end else begin
         radius_ff <= radius_in;
      end
   end

   // scan sequencer
   gnag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // address split, counters, lookahead cell and output register
   gnag_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cell_address   (req_cell_address),
      .radius             (radius_ff),
      .cmd                (cmd),
      .status             (status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_neighbour_cell (rsp_neighbour_cell),
      .rsp_is_last        (rsp_is_last)
   );

endmodule

[rtl/gnag_datapath.sv]
// Datapath: row/column split, distance counters, candidate cell and result registers.
// Depends on gnag_pkg; driven by gnag_ctrl through gnag_pkg::cmd_type.
module gnag_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gnag_pkg::ADDR_W-1:0]       req_cell_address,
   input  logic [gnag_pkg::RADIUS_W-1:0]     radius,
   input  gnag_pkg::cmd_type                 cmd,
   output gnag_pkg::status_type              status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [gnag_pkg::CELL_W-1:0]       rsp_neighbour_cell,
   output logic                              rsp_is_last
);

   logic [gnag_pkg::POS_W-1:0]    row_ff, row_in;
   logic [gnag_pkg::POS_W-1:0]    col_ff, col_in;
   logic [gnag_pkg::CNT_W-1:0]    r_ff, r_in;
   logic [gnag_pkg::CNT_W-1:0]    d_ff, d_in;
   logic [gnag_pkg::CNT_W-1:0]    k_ff, k_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [gnag_pkg::CELL_W-1:0]   pend_cell_ff, pend_cell_in;
   logic                          out_valid_ff, out_valid_in;
   logic [gnag_pkg::CELL_W-1:0]   out_cell_ff, out_cell_in;
   logic                          out_last_ff, out_last_in;

   logic [gnag_pkg::ADDR_W-1:0]   row_full;
   logic                          in_grid;
   logic [gnag_pkg::CNT_W-1:0]    r_clip;
   logic [gnag_pkg::CNT_W-1:0]    reach;
   logic [gnag_pkg::POS_W-1:0]    d_ext, k_ext;
   logic [gnag_pkg::POS_W-1:0]    row_pick, col_pick;
   logic [gnag_pkg::IDX_W-1:0]    cell_wide;
   logic                          push;

   // split the incoming address; an address outside the grid loads radius zero
   always_comb begin
      row_full = gnag_pkg::ADDR_W'(req_cell_address / gnag_pkg::GRID_SIDE);
      in_grid  = row_full < gnag_pkg::ADDR_W'(gnag_pkg::GRID_SIDE);
      if (radius > gnag_pkg::RADIUS_W'(gnag_pkg::RADIUS_MAX)) begin
         r_clip = gnag_pkg::CNT_W'(gnag_pkg::RADIUS_MAX);
      end else begin
         r_clip = gnag_pkg::CNT_W'(radius);
      end
   end

   // candidate cell and scan limits
   always_comb begin
      d_ext = gnag_pkg::POS_W'(d_ff);
      k_ext = gnag_pkg::POS_W'(k_ff);
      if (cmd.full_reach || r_ff == '0) begin
         reach = r_ff;
      end else begin
         reach = r_ff - gnag_pkg::CNT_W'(1);
      end

      unique case (cmd.row_sel)
         gnag_pkg::ROW_UP:   row_pick = row_ff - d_ext;
         gnag_pkg::ROW_DOWN: row_pick = row_ff + d_ext;
         default:            row_pick = row_ff;
      endcase

      unique case (cmd.col_sel)
         gnag_pkg::COL_LEFT:  col_pick = col_ff - k_ext;
         gnag_pkg::COL_RIGHT: col_pick = col_ff + k_ext;
         default:             col_pick = col_ff;
      endcase

      cell_wide = gnag_pkg::IDX_W'(row_pick) * gnag_pkg::IDX_W'(gnag_pkg::GRID_SIDE)
                + gnag_pkg::IDX_W'(col_pick);

      status.adv      = !out_valid_ff || !rsp_stall;
      status.up_ok    = (d_ff <= r_ff) && (d_ext <= row_ff);
      status.dn_ok    = (d_ff <= r_ff)
                     && ((row_ff + d_ext) < gnag_pkg::POS_W'(gnag_pkg::GRID_SIDE));
      status.left_ok  = (k_ff <= reach) && (k_ext <= col_ff);
      status.right_ok = (k_ff <= reach)
                     && ((col_ff + k_ext) < gnag_pkg::POS_W'(gnag_pkg::GRID_SIDE));
      status.d_at_r   = d_ff == r_ff;
   end

   // next-state of counters, pending cell and output register
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      r_in          = r_ff;
      d_in          = d_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_cell_in  = pend_cell_ff;
      out_valid_in  = out_valid_ff;
      out_cell_in   = out_cell_ff;
      out_last_in   = out_last_ff;

      if (cmd.load) begin
         row_in = gnag_pkg::POS_W'(row_full);
         col_in = gnag_pkg::POS_W'(req_cell_address % gnag_pkg::GRID_SIDE);
         r_in   = in_grid ? r_clip : '0;
      end

      if (cmd.load || cmd.d_reset) begin
         d_in = gnag_pkg::CNT_W'(1);
      end else if (cmd.d_next) begin
         d_in = d_ff + gnag_pkg::CNT_W'(1);
      end

      if (cmd.load || cmd.k_reset || cmd.d_next) begin
         k_in = gnag_pkg::CNT_W'(1);
      end else if (cmd.k_next) begin
         k_in = k_ff + gnag_pkg::CNT_W'(1);
      end

      // one cell of lookahead tells whether the pending cell is the last
      push = (cmd.emit || cmd.flush) && pend_valid_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_cell_in  = pend_cell_ff;
         out_last_in  = cmd.flush;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load || cmd.flush) begin
         pend_valid_in = 1'b0;
      end else if (cmd.emit) begin
         pend_valid_in = 1'b1;
         pend_cell_in  = cell_wide[gnag_pkg::CELL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      r_ff         <= r_in;
      d_ff         <= d_in;
      k_ff         <= k_in;
      pend_cell_ff <= pend_cell_in;
      out_cell_ff  <= out_cell_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_neighbour_cell = out_cell_ff;
   assign rsp_is_last        = out_last_ff;

endmodule

[rtl/gnag_ctrl.sv]
// Controller: walks rows above, rows below, own row; one scan step a cycle unless
// rsp stalls. Depends on gnag_pkg; commands gnag_datapath via gnag_pkg::cmd_type.
module gnag_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gnag_pkg::status_type  status,
   output gnag_pkg::cmd_type     cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_UP_C  = 4'd1;
   localparam logic [3:0] S_UP_L  = 4'd2;
   localparam logic [3:0] S_UP_R  = 4'd3;
   localparam logic [3:0] S_DN_C  = 4'd4;
   localparam logic [3:0] S_DN_L  = 4'd5;
   localparam logic [3:0] S_DN_R  = 4'd6;
   localparam logic [3:0] S_OWN_L = 4'd7;
   localparam logic [3:0] S_OWN_R = 4'd8;
   localparam logic [3:0] S_FLUSH = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = state_ff != S_IDLE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_UP_C;
            end
         end
         S_UP_C, S_DN_C: begin
            cmd.row_sel = (state_ff == S_UP_C) ? gnag_pkg::ROW_UP : gnag_pkg::ROW_DOWN;
            cmd.col_sel = gnag_pkg::COL_CENTRE;
            if (status.adv) begin
               if ((state_ff == S_UP_C) ? status.up_ok : status.dn_ok) begin
                  cmd.emit = 1'b1;
                  if (status.d_at_r) begin
                     cmd.d_next = 1'b1;
                  end else begin
                     state_in = (state_ff == S_UP_C) ? S_UP_L : S_DN_L;
                  end
               end else begin
                  cmd.d_reset = 1'b1;
                  state_in    = (state_ff == S_UP_C) ? S_DN_C : S_OWN_L;
               end
            end
         end
         S_UP_L, S_DN_L, S_OWN_L: begin
            unique case (state_ff)
               S_UP_L:  cmd.row_sel = gnag_pkg::ROW_UP;
               S_DN_L:  cmd.row_sel = gnag_pkg::ROW_DOWN;
               default: cmd.row_sel = gnag_pkg::ROW_OWN;
            endcase
            cmd.col_sel    = gnag_pkg::COL_LEFT;
            cmd.full_reach = state_ff == S_OWN_L;
            if (status.adv) begin
               if (status.left_ok) begin
                  cmd.emit   = 1'b1;
                  cmd.k_next = 1'b1;
               end else begin
                  cmd.k_reset = 1'b1;
                  unique case (state_ff)
                     S_UP_L:  state_in = S_UP_R;
                     S_DN_L:  state_in = S_DN_R;
                     default: state_in = S_OWN_R;
                  endcase
               end
            end
         end
         S_UP_R, S_DN_R, S_OWN_R: begin
            unique case (state_ff)
               S_UP_R:  cmd.row_sel = gnag_pkg::ROW_UP;
               S_DN_R:  cmd.row_sel = gnag_pkg::ROW_DOWN;
               default: cmd.row_sel = gnag_pkg::ROW_OWN;
            endcase
            cmd.col_sel    = gnag_pkg::COL_RIGHT;
            cmd.full_reach = state_ff == S_OWN_R;
            if (status.adv) begin
               if (status.right_ok) begin
                  cmd.emit   = 1'b1;
                  cmd.k_next = 1'b1;
               end else begin
                  unique case (state_ff)
                     S_UP_R: begin
                        cmd.d_next = 1'b1;
                        state_in   = S_UP_C;
                     end
                     S_DN_R: begin
                        cmd.d_next = 1'b1;
                        state_in   = S_DN_C;
                     end
                     default: state_in = S_FLUSH;
                  endcase
               end
            end
         end
         S_FLUSH: begin
            if (status.adv) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
